[hw/rtl/crre_pkg.sv]
// ----------------------------------------------------------------------------
// crre_pkg - shared types and constants for the clipped rectangle raster engine
// Word layouts, opcodes, register indexes and the span clip helper.
// ----------------------------------------------------------------------------
`default_nettype none

package crre_pkg;

	// Largest screen extent honored; fb_width / fb_height are capped here.
	localparam int MAX_DIM = 4096;

	localparam int COORD_W = $clog2(MAX_DIM);   // clipped column / row
	localparam int FB_W    = 13;
	localparam int PITCH_W = 17;
	localparam int OFF_W   = 28;
	localparam int COLOR_W = 32;
	localparam int RECT_W  = 16;
	localparam int SW      = RECT_W + 2;        // signed span math width
	localparam int MUL_W   = COORD_W + PITCH_W;

	localparam int NUM_SPANS = 4;
	localparam int PH_W      = $clog2(NUM_SPANS);

	localparam int CQ_DEPTH = 4;                // front to back queue
	localparam int CQ_AW    = $clog2(CQ_DEPTH);

	// opcodes
	localparam logic [1:0] OP_STEP    = 2'd0;
	localparam logic [1:0] OP_FILL    = 2'd1;
	localparam logic [1:0] OP_OUTLINE = 2'd2;

	// register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd3;

	localparam logic [FB_W-1:0]    FB_WIDTH_RST  = 13'd1280;
	localparam logic [FB_W-1:0]    FB_HEIGHT_RST = 13'd720;
	localparam logic [PITCH_W-1:0] ROW_PITCH_RST = 17'd5120;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [RECT_W-1:0] rect_x;
		logic signed [RECT_W-1:0] rect_y;
		logic signed [RECT_W-1:0] rect_w;
		logic signed [RECT_W-1:0] rect_h;
		logic [COLOR_W-1:0]       color;
	} cmd_t;

	typedef struct packed {
		logic               write_valid;
		logic [OFF_W-1:0]   byte_offset;
		logic [COLOR_W-1:0] pixel_color;
		logic               last;
		logic               busy_res;
		logic               accepted;
	} res_t;

	// one write descriptor, front to back
	typedef struct packed {
		logic               write_valid;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [COLOR_W-1:0] color;
		logic               last;
		logic               busy_res;
		logic               accepted;
	} wdesc_t;

	typedef struct packed {
		logic [COORD_W-1:0] c0;
		logic [COORD_W-1:0] c1;
		logic [COORD_W-1:0] r0;
		logic [COORD_W-1:0] r1;
	} span_t;

	typedef struct packed {
		logic               ok;
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
	} clip_t;

	// Clamp [lo, hi] to [0, lim-1]; ok is low when nothing is left.
	function automatic clip_t clip(input logic signed [SW-1:0] lo,
			input logic signed [SW-1:0] hi, input logic signed [SW-1:0] lim);
		logic signed [SW-1:0] l;
		logic signed [SW-1:0] h;
		logic signed [SW-1:0] top;
		clip_t r;
		top  = SW'(lim - 1);
		l    = (lo < 0) ? '0 : lo;
		h    = (hi > top) ? top : hi;
		r.ok = (l <= h);
		r.lo = COORD_W'(l);
		r.hi = COORD_W'(h);
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/clipped_rect_raster_engine_unit.sv]
// ----------------------------------------------------------------------------
// clipped_rect_raster_engine_unit - clipped rectangle fill / outline engine
// 32-bit-per-pixel framebuffer write generator with screen clipping.
// ----------------------------------------------------------------------------
// Every accepted word yields exactly one result word, in order. A start word
// (fill or outline) clips all of its spans against the screen in the cycle it
// is taken and answers with accepted/busy_res; each later step word yields one
// pixel write (byte offset row*row_pitch + col*4, wrapped to 28 bits) with
// last set on the final write. One word is taken per clock as long as the
// result side drains: the span sequencer advances its cursor with each step
// word it takes and the offset multiply is pipelined. A result becomes
// visible once its word has passed the descriptor queue, the multiply stage,
// the add stage and the result buffer. A four-word descriptor queue plus a
// two-word result buffer let the input side keep going while a result waits
// to be popped. Register writes take effect at once; row_pitch is used as
// each write enters the multiply stage, so change the registers only while
// no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_rect_raster_engine_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// command side
	input  wire logic                             push,
	output logic                                  full,
	input  wire crre_pkg::cmd_t                   cmd,
	// result side
	output logic                                  empty,
	input  wire logic                             pop,
	output crre_pkg::res_t                        res,
	// register writes
	input  wire logic                             cfg_we,
	input  wire logic [crre_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [crre_pkg::PITCH_W-1:0]     cfg_data
);

	// configuration registers
	logic [crre_pkg::FB_W-1:0]    fb_width_q;
	logic [crre_pkg::FB_W-1:0]    fb_height_q;
	logic [crre_pkg::PITCH_W-1:0] row_pitch_q;
	logic                         enable_q;

	logic              acc;      // word taken this cycle
	crre_pkg::wdesc_t  desc;
	crre_pkg::wdesc_t  q_head;
	logic              q_empty, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_width_q  <= crre_pkg::FB_WIDTH_RST;
			fb_height_q <= crre_pkg::FB_HEIGHT_RST;
			row_pitch_q <= crre_pkg::ROW_PITCH_RST;
			enable_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				crre_pkg::REG_FB_WIDTH:  fb_width_q  <= cfg_data[crre_pkg::FB_W-1:0];
				crre_pkg::REG_FB_HEIGHT: fb_height_q <= cfg_data[crre_pkg::FB_W-1:0];
				crre_pkg::REG_ROW_PITCH: row_pitch_q <= cfg_data;
				crre_pkg::REG_ENABLE:    enable_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// full comes straight from the descriptor queue count: no path from pop
	assign acc = push && !full;

	crre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.cmd       (cmd),
		.fb_width  (fb_width_q),
		.fb_height (fb_height_q),
		.enable    (enable_q),
		.desc      (desc)
	);

	crre_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (acc),
		.wdata   (desc),
		.q_full  (full),
		.rd      (q_pop),
		.q_empty (q_empty),
		.head    (q_head)
	);

	crre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.row_pitch (row_pitch_q),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	a_empty_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !res.write_valid |-> (res.byte_offset == '0) && (res.pixel_color == '0))
		else $error("non-write result carries data");

endmodule

`default_nettype wire

[hw/rtl/crre_front.sv]
// ----------------------------------------------------------------------------
// crre_front - command front end
// Takes words, clips all spans of a start at once, sequences pixel steps.
// ----------------------------------------------------------------------------
`default_nettype none

module crre_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        acc,
	input  wire crre_pkg::cmd_t              cmd,
	input  wire logic [crre_pkg::FB_W-1:0]   fb_width,
	input  wire logic [crre_pkg::FB_W-1:0]   fb_height,
	input  wire logic                        enable,
	output crre_pkg::wdesc_t                 desc
);

	localparam int SW = crre_pkg::SW;
	localparam int CW = crre_pkg::COORD_W;
	localparam int NS = crre_pkg::NUM_SPANS;
	localparam int PW = crre_pkg::PH_W;

	logic                  active_q;
	logic [PW-1:0]         phase_q;
	logic [NS-1:0]         ok_q;
	crre_pkg::span_t       span_q [NS];
	logic [CW-1:0]         col_q;
	logic [CW-1:0]         row_q;
	logic [crre_pkg::COLOR_W-1:0] color_q;

	logic signed [SW-1:0]  x_e, y_e, w_e, h_e, xr_e, yb_e, lw, lh;
	logic                  w_pos, h_pos, is_start, load, stepping;
	crre_pkg::clip_t       cf, rf, rt, rb, cl, cr;
	crre_pkg::span_t       new_span [NS];
	logic [NS-1:0]         new_ok;
	logic                  new_any, nxt_any, span_done;
	logic [PW-1:0]         new_first, nxt_ph;
	crre_pkg::span_t       cur;

	// screen limits, capped
	assign lw = (SW'(fb_width) > SW'(crre_pkg::MAX_DIM)) ?
		SW'(crre_pkg::MAX_DIM) : SW'(fb_width);
	assign lh = (SW'(fb_height) > SW'(crre_pkg::MAX_DIM)) ?
		SW'(crre_pkg::MAX_DIM) : SW'(fb_height);

	assign x_e  = SW'(cmd.rect_x);
	assign y_e  = SW'(cmd.rect_y);
	assign w_e  = SW'(cmd.rect_w);
	assign h_e  = SW'(cmd.rect_h);
	assign xr_e = SW'(x_e + w_e - 1);
	assign yb_e = SW'(y_e + h_e - 1);
	assign w_pos = (w_e > 0);
	assign h_pos = (h_e > 0);

	assign cf = crre_pkg::clip(x_e, xr_e, lw);
	assign rf = crre_pkg::clip(y_e, yb_e, lh);
	assign rt = crre_pkg::clip(y_e, y_e, lh);
	assign rb = crre_pkg::clip(yb_e, yb_e, lh);
	assign cl = crre_pkg::clip(x_e, x_e, lw);
	assign cr = crre_pkg::clip(xr_e, xr_e, lw);

	// span table: fill uses only span 0; outline is top, bottom, left, right
	always_comb begin
		new_span[0] = '{c0: cf.lo, c1: cf.hi, r0: rf.lo, r1: rf.hi};
		new_span[1] = '{c0: cf.lo, c1: cf.hi, r0: rb.lo, r1: rb.hi};
		new_span[2] = '{c0: cl.lo, c1: cl.hi, r0: rf.lo, r1: rf.hi};
		new_span[3] = '{c0: cr.lo, c1: cr.hi, r0: rf.lo, r1: rf.hi};
		new_ok      = '0;
		if (cmd.op == crre_pkg::OP_FILL) begin
			new_ok[0] = w_pos && h_pos && cf.ok && rf.ok;
		end else begin
			new_span[0] = '{c0: cf.lo, c1: cf.hi, r0: rt.lo, r1: rt.hi};
			new_ok[0]   = w_pos && cf.ok && rt.ok;
			new_ok[1]   = w_pos && cf.ok && rb.ok;
			new_ok[2]   = h_pos && cl.ok && rf.ok;
			new_ok[3]   = h_pos && cr.ok && rf.ok;
		end
	end

	// first live span of a new command, next live span after the current one
	always_comb begin
		new_any   = 1'b0;
		new_first = '0;
		nxt_any   = 1'b0;
		nxt_ph    = '0;
		for (int p = NS - 1; p >= 0; p--) begin
			if (new_ok[p]) begin
				new_any   = 1'b1;
				new_first = PW'(p);
			end
			if (ok_q[p] && (PW'(p) > phase_q)) begin
				nxt_any = 1'b1;
				nxt_ph  = PW'(p);
			end
		end
	end

	assign cur       = span_q[phase_q];
	assign span_done = (col_q >= cur.c1) && (row_q >= cur.r1);
	assign is_start  = (cmd.op == crre_pkg::OP_FILL) || (cmd.op == crre_pkg::OP_OUTLINE);
	assign load      = acc && is_start && !active_q && enable;
	assign stepping  = acc && !is_start && active_q;

	always_comb begin
		desc = '0;
		if (is_start) begin
			if (active_q) begin
				desc.busy_res = 1'b1;   // refused
			end else begin
				desc.accepted = 1'b1;
				desc.busy_res = enable && new_any;
			end
		end else if (active_q) begin
			desc.write_valid = 1'b1;
			desc.row         = row_q;
			desc.col         = col_q;
			desc.color       = color_q;
			desc.last        = span_done && !nxt_any;
			desc.busy_res    = !(span_done && !nxt_any);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= '0;
			ok_q     <= '0;
		end else if (load) begin
			active_q <= new_any;
			ok_q     <= new_ok;
			phase_q  <= new_first;
		end else if (stepping && span_done) begin
			if (nxt_any) begin
				phase_q <= nxt_ph;
			end else begin
				active_q <= 1'b0;
				phase_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			span_q  <= new_span;
			color_q <= cmd.color;
			col_q   <= new_span[new_first].c0;
			row_q   <= new_span[new_first].r0;
		end else if (stepping) begin
			if (col_q < cur.c1) begin
				col_q <= col_q + 1'b1;
			end else if (row_q < cur.r1) begin
				col_q <= cur.c0;
				row_q <= row_q + 1'b1;
			end else if (nxt_any) begin
				col_q <= span_q[nxt_ph].c0;
				row_q <= span_q[nxt_ph].r0;
			end
		end
	end

	a_active_span_live: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ok_q[phase_q])
		else $error("active with a dead span");

	a_cursor_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (col_q >= cur.c0) && (col_q <= cur.c1) &&
			(row_q >= cur.r0) && (row_q <= cur.r1))
		else $error("cursor outside span");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		acc && desc.last |=> !active_q)
		else $error("last write but engine still active");

endmodule

`default_nettype wire

[hw/rtl/crre_cmd_queue.sv]
// ----------------------------------------------------------------------------
// crre_cmd_queue - write descriptor queue
// Short register queue between the front end and the offset pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module crre_cmd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire crre_pkg::wdesc_t  wdata,
	output logic                   q_full,
	input  wire logic              rd,
	output logic                   q_empty,
	output crre_pkg::wdesc_t       head
);

	localparam int AW = crre_pkg::CQ_AW;

	crre_pkg::wdesc_t  mem_q [crre_pkg::CQ_DEPTH];
	logic [AW-1:0]     wptr_q, rptr_q;
	logic [AW:0]       count_q;
	logic              do_wr, do_rd;

	assign q_full  = (count_q == (AW+1)'(crre_pkg::CQ_DEPTH));
	assign q_empty = (count_q == '0);
	assign head    = mem_q[rptr_q];
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 1'b1;
			if (do_rd) rptr_q <= rptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(crre_pkg::CQ_DEPTH))
		else $error("queue count overflow");

endmodule

`default_nettype wire

[hw/rtl/crre_back.sv]
// ----------------------------------------------------------------------------
// crre_back - offset pipeline and result buffer
// row*pitch in stage 1, plus col*4 in stage 2, then a two-word result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module crre_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_empty,
	input  wire crre_pkg::wdesc_t               q_head,
	output logic                                q_pop,
	input  wire logic [crre_pkg::PITCH_W-1:0]   row_pitch,
	output logic                                empty,
	input  wire logic                           pop,
	output crre_pkg::res_t                      res
);

	localparam int OW = crre_pkg::OFF_W;
	localparam int MW = crre_pkg::MUL_W;
	localparam int OB_DEPTH = 2;

	// stage 1
	logic                       valid_s1;
	logic [OW-1:0]              rowoff_s1;
	crre_pkg::wdesc_t           desc_s1;
	// stage 2
	logic                       valid_s2;
	crre_pkg::res_t             res_s2;
	// result buffer
	crre_pkg::res_t             ob_q [OB_DEPTH];
	logic                       ob_wptr_q, ob_rptr_q;
	logic [1:0]                 ob_cnt_q;

	logic                       ob_full, ob_push, ob_pop, advance;
	logic [MW-1:0]              mul;

	assign ob_full = (ob_cnt_q == 2'(OB_DEPTH));
	assign advance = !valid_s2 || !ob_full;
	assign q_pop   = advance && !q_empty;
	assign ob_push = valid_s2 && !ob_full;
	assign ob_pop  = pop && !empty;
	assign empty   = (ob_cnt_q == '0);
	assign res     = ob_q[ob_rptr_q];
	assign mul     = MW'(q_head.row) * MW'(row_pitch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= q_pop;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rowoff_s1              <= OW'(mul);
			desc_s1                <= q_head;
			res_s2.write_valid     <= desc_s1.write_valid;
			res_s2.byte_offset     <= rowoff_s1 + OW'({desc_s1.col, 2'b00});
			res_s2.pixel_color     <= desc_s1.color;
			res_s2.last            <= desc_s1.last;
			res_s2.busy_res        <= desc_s1.busy_res;
			res_s2.accepted        <= desc_s1.accepted;
		end
		if (ob_push) begin
			ob_q[ob_wptr_q] <= res_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wptr_q <= 1'b0;
			ob_rptr_q <= 1'b0;
			ob_cnt_q  <= '0;
		end else begin
			if (ob_push) ob_wptr_q <= !ob_wptr_q;
			if (ob_pop)  ob_rptr_q <= !ob_rptr_q;
			if (ob_push && !ob_pop) ob_cnt_q <= ob_cnt_q + 1'b1;
			else if (ob_pop && !ob_push) ob_cnt_q <= ob_cnt_q - 1'b1;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ob_full && !ob_pop |=> valid_s2 && $stable(res_s2))
		else $error("stage 2 word lost under stall");

endmodule

`default_nettype wire
